/* design/tdbd_pkg.sv */
// ----------------------------------------------------------------------------
// tdbd_pkg
// Shared types, codes and constants of the table-driven block decrypt unit.
// ----------------------------------------------------------------------------
package tdbd_pkg;

  localparam int KeySetsDef  = 101;
  localparam int Rounds      = 17;
  localparam int WordsPerSet = 68;
  localparam int TableDepth  = 69632;
  localparam int KeySetW     = 8;   // holds any set index up to 256 sets

  localparam logic [1:0] CMD_LOAD_TABLE = 2'd0;
  localparam logic [1:0] CMD_LOAD_KEY   = 2'd1;
  localparam logic [1:0] CMD_DECRYPT    = 2'd2;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_TBL  = 2'd1,
    KIND_KEY  = 2'd2,
    KIND_DEC  = 2'd3
  } kind_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [16:0] load_address;
    logic [31:0] load_word;
    logic [63:0] block_low;
    logic [63:0] block_high;
  } in_item_t;

  typedef struct packed {
    logic [63:0] plain_low;
    logic [63:0] plain_high;
  } out_item_t;

  // One transaction as it moves down the round pipeline.
  typedef struct packed {
    kind_e               kind;
    logic [16:0]         tbl_addr;
    logic [KeySetW-1:0]  key_set;
    logic [6:0]          key_slot;
    logic [31:0]         word;
    logic [127:0]        block;
  } token_t;

  localparam logic [3:0] LanePerm [16] = '{
    4'd0, 4'd7, 4'd10, 4'd13, 4'd1, 4'd4, 4'd11, 4'd14,
    4'd2, 4'd5, 4'd8, 4'd15, 4'd3, 4'd6, 4'd9, 4'd12
  };

  function automatic logic [3:0] lane_pos(input logic shuffle, input logic [3:0] idx);
    lane_pos = shuffle ? LanePerm[idx] : idx;
  endfunction

endpackage

/* design/tdbd_front.sv */
// ----------------------------------------------------------------------------
// tdbd_front
// Decodes incoming transactions and splits key addresses into set and slot.
// ----------------------------------------------------------------------------
module tdbd_front #(
  parameter int KEY_SETS = tdbd_pkg::KeySetsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              take_i,
  input  tdbd_pkg::in_item_t item_i,
  output tdbd_pkg::token_t  tok_o
);

  localparam int KeyDepth = KEY_SETS * tdbd_pkg::WordsPerSet;
  localparam int MulK     = (1 << 24) / tdbd_pkg::WordsPerSet;

  tdbd_pkg::token_t s1_d, s1_q, tok_d, tok_q;
  logic [34:0]      prod_d, prod_q;
  logic [10:0]      quo;
  logic [16:0]      rem, prod_back;
  logic [10:0]      quo_fix;
  logic [16:0]      rem_fix;

  always_comb begin
    s1_d          = '0;
    s1_d.kind     = tdbd_pkg::KIND_NONE;
    s1_d.tbl_addr = item_i.load_address;
    s1_d.word     = item_i.load_word;
    s1_d.block    = {item_i.block_high, item_i.block_low};
    if (take_i) begin
      unique case (item_i.cmd)
        tdbd_pkg::CMD_LOAD_TABLE: begin
          if (32'(item_i.load_address) < 32'(tdbd_pkg::TableDepth)) s1_d.kind = tdbd_pkg::KIND_TBL;
        end
        tdbd_pkg::CMD_LOAD_KEY: begin
          if (32'(item_i.load_address) < 32'(KeyDepth)) s1_d.kind = tdbd_pkg::KIND_KEY;
        end
        tdbd_pkg::CMD_DECRYPT: s1_d.kind = tdbd_pkg::KIND_DEC;
        default:               s1_d.kind = tdbd_pkg::KIND_NONE;
      endcase
    end
    prod_d = 35'(item_i.load_address) * 35'(MulK);
  end

  // reciprocal estimate is low by at most one
  always_comb begin
    quo       = prod_q[34:24];
    prod_back = 17'(quo) * 17'(tdbd_pkg::WordsPerSet);
    rem       = s1_q.tbl_addr - prod_back;
    quo_fix   = quo;
    rem_fix   = rem;
    if (rem >= 17'(tdbd_pkg::WordsPerSet)) begin
      quo_fix = quo + 11'd1;
      rem_fix = rem - 17'(tdbd_pkg::WordsPerSet);
    end
    tok_d          = s1_q;
    tok_d.key_set  = tdbd_pkg::KeySetW'(quo_fix);
    tok_d.key_slot = 7'(rem_fix);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q.kind  <= tdbd_pkg::KIND_NONE;
      tok_q.kind <= tdbd_pkg::KIND_NONE;
    end else if (en_i) begin
      s1_q  <= s1_d;
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) prod_q <= prod_d;
  end

  assign tok_o = tok_q;

endmodule

/* design/tdbd_round.sv */
// ----------------------------------------------------------------------------
// tdbd_round
// One cipher round: sixteen banked table lookups, key read, XOR merge.
// ----------------------------------------------------------------------------
module tdbd_round #(
  parameter int KEY_SETS = tdbd_pkg::KeySetsDef,
  parameter int ROUND    = 0
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic [tdbd_pkg::KeySetW-1:0]  key_set_i,
  input  tdbd_pkg::token_t              tok_i,
  output tdbd_pkg::token_t              tok_o
);

  localparam int  SetW    = (KEY_SETS > 1) ? $clog2(KEY_SETS) : 1;
  localparam logic Shuffle = (ROUND >= 2) && (ROUND <= 15);

  tdbd_pkg::token_t tok_b_q, tok_d, tok_q;
  logic [31:0]      trd_q [16];
  logic [31:0]      krd_q [4];
  logic             tbl_hit, key_hit;

  assign tbl_hit = (tok_i.kind == tdbd_pkg::KIND_TBL) && (tok_i.tbl_addr[16:12] == 5'(ROUND));
  assign key_hit = (tok_i.kind == tdbd_pkg::KIND_KEY) && (tok_i.key_slot[6:2] == 5'(ROUND));

  for (genvar i = 0; i < 16; i++) begin : g_lane
    localparam logic [3:0] Pos = tdbd_pkg::lane_pos(Shuffle, 4'(i));
    logic [31:0] tbl_mem [256];
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (tbl_hit && tok_i.tbl_addr[11:8] == Pos) begin
          tbl_mem[tok_i.tbl_addr[7:0]] <= tok_i.word;
        end
        trd_q[i] <= tbl_mem[tok_i.block[8*Pos +: 8]];
      end
    end
  end

  for (genvar w = 0; w < 4; w++) begin : g_key
    logic [31:0] key_mem [KEY_SETS];
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (key_hit && tok_i.key_slot[1:0] == 2'(w)) begin
          key_mem[tok_i.key_set[SetW-1:0]] <= tok_i.word;
        end
        krd_q[w] <= key_mem[key_set_i[SetW-1:0]];
      end
    end
  end

  always_comb begin
    tok_d = tok_b_q;
    if (tok_b_q.kind == tdbd_pkg::KIND_DEC) begin
      for (int r = 0; r < 4; r++) begin
        tok_d.block[32*r +: 32] = krd_q[r] ^ trd_q[4*r] ^ trd_q[4*r+1]
                                ^ trd_q[4*r+2] ^ trd_q[4*r+3];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_b_q.kind <= tdbd_pkg::KIND_NONE;
      tok_q.kind   <= tdbd_pkg::KIND_NONE;
    end else if (en_i) begin
      tok_b_q <= tok_i;
      tok_q   <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

/* design/table_driven_block_decrypt_unit.sv */
// Pipeline: 2 decode stages, then 2 stages per round for 17 rounds (banked table
// read, then XOR merge).
// Throughput: one transaction per cycle; the whole pipeline freezes while a
// result is stalled at the output.
// Reset clears the pipeline valid state and key_select; table and key stores
// are not cleared and hold garbage until loaded.
// ----------------------------------------------------------------------------
// table_driven_block_decrypt_unit
// Seventeen-round table-driven 16-byte block decryptor, fully pipelined.
// ----------------------------------------------------------------------------
module table_driven_block_decrypt_unit #(
  parameter int KEY_SETS = tdbd_pkg::KeySetsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [6:0]          cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  tdbd_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tdbd_pkg::out_item_t out_data_o
);

  localparam int SetW = (KEY_SETS > 1) ? $clog2(KEY_SETS) : 1;

  logic                          en;
  logic [tdbd_pkg::KeySetW-1:0]  key_set_d, key_set_q;
  logic [SetW-1:0]               set_lut [128];
  tdbd_pkg::token_t              tok [tdbd_pkg::Rounds + 1];

  // key_select modulo KEY_SETS, folded into a constant table
  for (genvar i = 0; i < 128; i++) begin : g_lut
    assign set_lut[i] = SetW'(i % KEY_SETS);
  end

  assign key_set_d = tdbd_pkg::KeySetW'(set_lut[cfg_wdata_i]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_set_q <= '0;
    end else if (cfg_we_i) begin
      key_set_q <= key_set_d;
    end
  end

  // Global advance: everything moves unless a finished result is held.
  assign en          = !(out_valid_o && out_stall_i);
  assign in_stall_o  = !en;

  tdbd_front #(
    .KEY_SETS (KEY_SETS)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .take_i (in_valid_i),
    .item_i (in_data_i),
    .tok_o  (tok[0])
  );

  for (genvar r = 0; r < tdbd_pkg::Rounds; r++) begin : g_round
    tdbd_round #(
      .KEY_SETS (KEY_SETS),
      .ROUND    (r)
    ) u_round (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (en),
      .key_set_i (key_set_q),
      .tok_i     (tok[r]),
      .tok_o     (tok[r+1])
    );
  end

  // Loads drain off the end unseen; only decrypts become results.
  assign out_valid_o           = (tok[tdbd_pkg::Rounds].kind == tdbd_pkg::KIND_DEC);
  assign out_data_o.plain_low  = tok[tdbd_pkg::Rounds].block[63:0];
  assign out_data_o.plain_high = tok[tdbd_pkg::Rounds].block[127:64];

  a_set_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(key_set_q) < 32'(KEY_SETS)) else $error("key set out of range");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o) else $error("input stalled without held result");

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o) else $error("held result lost");

endmodule
